@@ hw/rtl/sem_pkg.sv @@
// package for the semaphore table: command, status and state codes, payload types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_WAIT    = 2'd1,
		CMD_POST    = 2'd2,
		CMD_DESTROY = 2'd3
	} cmd_t;

	// input transaction payload
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  sem_id;
		logic [15:0] init_value;
		logic [7:0]  task_id;
	} sem_cmd_t;

	// result transaction payload
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] new_id;
		logic       woke_valid;
		logic [7:0] woke_task;
		logic       last;
	} sem_res_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BLOCKED    = 3'd1;
	localparam logic [2:0] ST_BAD_ID     = 3'd2;
	localparam logic [2:0] ST_NOT_VALID  = 3'd3;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL = 3'd5;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DRAIN_RD,
		S_DRAIN_OUT,
		S_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       load_item;
		logic       lookup;
		logic       scan_clear;
		logic       scan_step;
		logic       create_slot;
		logic       wait_take;
		logic       wait_enqueue;
		logic       post_apply;
		logic       shift_read;
		logic       shift_write;
		logic       drain_read;
		logic       destroy_slot;
		logic       res_load;
		logic [2:0] res_status;
		logic       res_new_id;
		logic       res_woke;
		logic       res_last;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic id_bad;
		logic slot_ok;
		logic count_pos;
		logic queue_full;
		logic queue_empty;
		logic scan_free;
		logic scan_done;
		logic idx_last;
	} sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/sem_stream_if.sv @@
// valid/ready channel with a generic payload
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface sem_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/semaphore_table_with_wait_queues.sv @@
// semaphore table with per-slot wait queues, controller plus datapath
// create scans the slots in order for a free one; post with waiters shifts the queue
// through one memory port; destroy with waiters gives one result transaction each,
// and every result waits for ready
// one command at a time; reset clears slot valid bits and queue totals at once
`timescale 1ns / 1ps
`default_nettype none
module semaphore_table_with_wait_queues
	import sem_pkg::*;
#(
	parameter int SEM_COUNT   = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input wire clk,
	input wire arst_n,
	sem_stream_if.sink   cmd_in,
	sem_stream_if.source res_out
);
	ctl_t ctl;
	sts_t sts;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.in_ready  (cmd_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sem_datapath #(
		.SEM_COUNT   (SEM_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_in.data.cmd),
		.sem_id     (cmd_in.data.sem_id),
		.init_value (cmd_in.data.init_value),
		.task_id    (cmd_in.data.task_id),
		.ctl        (ctl),
		.out_take   (res_out.valid && res_out.ready),
		.sts        (sts),
		.status     (res_out.data.status),
		.new_id     (res_out.data.new_id),
		.woke_valid (res_out.data.woke_valid),
		.woke_task  (res_out.data.woke_task),
		.last       (res_out.data.last)
	);
endmodule
`default_nettype wire

@@ hw/rtl/sem_ctrl.sv @@
// controller state machine for the semaphore table
// depends on sem_pkg
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl
	import sem_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	input  sts_t sts,
	output ctl_t ctl
);
	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	// state and output flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	// take a new command only in idle and when the result register is free or being taken
	assign in_ready  = (state_q == S_IDLE) && !(out_valid_q && !out_ready);

	// next state and commands
	always_comb begin
		logic slot_free;
		slot_free   = out_valid_q && !out_ready;
		state_d     = state_q;
		ctl         = '0;
		ctl.res_status = ST_OK;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !slot_free) begin
					ctl.load_item  = 1'b1;
					ctl.scan_clear = 1'b1;
					state_d        = S_READ;
				end
			end
			S_READ: begin
				// id is now registered; slot state is looked up and registered here
				ctl.lookup = 1'b1;
				if (sts.cmd == CMD_CREATE) begin
					state_d = S_SEARCH;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_SEARCH: begin
				if (sts.scan_free) begin
					ctl.create_slot = 1'b1;
					ctl.res_load    = 1'b1;
					ctl.res_status  = ST_OK;
					ctl.res_new_id  = 1'b1;
					ctl.res_last    = 1'b1;
					state_d         = S_OUT;
				end else if (sts.scan_done) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = ST_TABLE_FULL;
					ctl.res_last   = 1'b1;
					state_d        = S_OUT;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_DECIDE: begin
				ctl.res_last = 1'b1;
				state_d      = S_OUT;
				priority if (sts.id_bad) begin
					ctl.res_status = ST_BAD_ID;
				end else if (!sts.slot_ok) begin
					ctl.res_status = ST_NOT_VALID;
				end else if (sts.cmd == CMD_WAIT) begin
					priority if (sts.count_pos) begin
						ctl.wait_take = 1'b1;
					end else if (sts.queue_full) begin
						ctl.res_status = ST_QUEUE_FULL;
					end else begin
						ctl.wait_enqueue = 1'b1;
						ctl.res_status   = ST_BLOCKED;
					end
				end else if (sts.cmd == CMD_POST) begin
					ctl.post_apply = 1'b1;
					if (!sts.queue_empty) begin
						ctl.res_woke = 1'b1;
						ctl.res_load = 1'b0;
						state_d      = S_SHIFT_RD;
						ctl.shift_read = 1'b1;
					end
				end else begin
					if (sts.queue_empty) begin
						ctl.destroy_slot = 1'b1;
					end else begin
						ctl.res_last   = 1'b0;
						ctl.drain_read = 1'b1;
						state_d        = S_DRAIN_OUT;
					end
				end
				if (state_d == S_OUT) begin
					ctl.res_load = 1'b1;
				end
			end
			S_SHIFT_RD: begin
				// head is latched; read next entry to move down
				if (sts.idx_last) begin
					ctl.res_load  = 1'b1;
					ctl.res_woke  = 1'b1;
					ctl.res_last  = 1'b1;
					ctl.res_status = ST_OK;
					state_d       = S_OUT;
				end else begin
					ctl.shift_read = 1'b1;
					state_d        = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				ctl.shift_write = 1'b1;
				state_d         = S_SHIFT_RD;
			end
			S_DRAIN_OUT: begin
				// read data of one waiter is ready
				if (!slot_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_woke   = 1'b1;
					ctl.res_status = ST_OK;
					ctl.res_last   = sts.idx_last;
					out_valid_d    = 1'b1;
					if (sts.idx_last) begin
						ctl.destroy_slot = 1'b1;
						state_d          = S_IDLE;
					end else begin
						ctl.drain_read = 1'b1;
						state_d        = S_DRAIN_RD;
					end
				end
			end
			S_DRAIN_RD: begin
				state_d = S_DRAIN_OUT;
			end
			S_OUT: begin
				if (!slot_free) begin
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/sem_datapath.sv @@
// datapath: slot table, counts, waiter memory and result register
// depends on sem_pkg
`timescale 1ns / 1ps
`default_nettype none
module sem_datapath
	import sem_pkg::*;
#(
	parameter int SEM_COUNT   = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [1:0]  cmd,
	input  wire  [7:0]  sem_id,
	input  wire  [15:0] init_value,
	input  wire  [7:0]  task_id,
	input  ctl_t        ctl,
	input  wire         out_take,
	output sts_t        sts,
	output logic [2:0]  status,
	output logic [7:0]  new_id,
	output logic        woke_valid,
	output logic [7:0]  woke_task,
	output logic        last
);
	localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = SEM_COUNT * QUEUE_DEPTH;
	localparam int AW = (MD > 1) ? $clog2(MD) : 1;

	logic [SEM_COUNT-1:0] valid_q;
	logic [NW-1:0]        total_q [SEM_COUNT];
	logic [15:0]          count_q [SEM_COUNT];
	logic [7:0]           wmem [MD];

	cmd_t        cmd_q;
	logic [7:0]  id_q;
	logic [15:0] init_q;
	logic [7:0]  task_q;
	logic [SW-1:0] slot_q;
	logic [SW:0]   scan_q;
	logic [NW-1:0] n_q;
	logic [15:0]   cnt_q;
	logic          ok_q;
	logic [NW-1:0] idx_q;
	logic [7:0]    rd_q;
	logic [7:0]    head_q;

	logic [SW-1:0] scan_idx;
	logic [AW-1:0] base;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          we;
	logic [7:0]    wd;

	assign scan_idx = scan_q[SW-1:0];
	assign base     = AW'(slot_q) * AW'(QUEUE_DEPTH);

	// item latch and slot lookup, snapshot held for the whole command
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q  <= cmd_t'(cmd);
			id_q   <= sem_id;
			init_q <= init_value;
			task_q <= task_id;
			slot_q <= SW'(sem_id);
		end else if (ctl.scan_step) begin
			slot_q <= SW'(scan_q + 1'b1);
		end
		if (ctl.lookup) begin
			n_q   <= total_q[slot_q];
			cnt_q <= count_q[slot_q];
			ok_q  <= valid_q[slot_q];
		end
	end

	// free slot scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.scan_clear) begin
			scan_q <= '0;
		end else if (ctl.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// slot state tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SEM_COUNT; i++) begin
				total_q[i] <= '0;
			end
		end else begin
			if (ctl.create_slot) begin
				valid_q[scan_idx] <= 1'b1;
				total_q[scan_idx] <= '0;
			end
			if (ctl.wait_enqueue) begin
				total_q[slot_q] <= n_q + 1'b1;
			end
			if (ctl.post_apply && n_q != '0) begin
				total_q[slot_q] <= n_q - 1'b1;
			end
			if (ctl.destroy_slot) begin
				valid_q[slot_q] <= 1'b0;
				total_q[slot_q] <= '0;
			end
		end
	end

	// counts
	always_ff @(posedge clk) begin
		if (ctl.create_slot) begin
			count_q[scan_idx] <= init_q;
		end else if (ctl.wait_take) begin
			count_q[slot_q] <= cnt_q - 16'd1;
		end else if (ctl.post_apply && cnt_q != COUNT_MAX) begin
			count_q[slot_q] <= cnt_q + 16'd1;
		end
	end

	// queue walk index: shift walks from 1, drain from 0
	always_ff @(posedge clk) begin
		if (ctl.post_apply) begin
			idx_q <= NW'(1);
		end else if (ctl.shift_write) begin
			idx_q <= idx_q + 1'b1;
		end else if (ctl.drain_read) begin
			idx_q <= (cmd_q == CMD_DESTROY && !ctl.res_load) ? NW'(1) : idx_q + 1'b1;
		end
	end

	// waiter memory, one write and one registered read port
	always_comb begin
		rd_addr = base;
		if (ctl.shift_read && !ctl.post_apply) begin
			rd_addr = base + AW'(idx_q);
		end else if (ctl.drain_read && ctl.res_load) begin
			rd_addr = base + AW'(idx_q);
		end
		we      = 1'b0;
		wr_addr = base + AW'(n_q);
		wd      = task_q;
		if (ctl.wait_enqueue) begin
			we = 1'b1;
		end else if (ctl.shift_write) begin
			we      = 1'b1;
			wr_addr = base + AW'(idx_q - 1'b1);
			wd      = rd_q;
		end
	end

	// read data is held until the next commanded read
	always_ff @(posedge clk) begin
		if (we) begin
			wmem[wr_addr] <= wd;
		end
		if (ctl.shift_read || ctl.drain_read || ctl.post_apply) begin
			rd_q <= wmem[rd_addr];
		end
		if (ctl.post_apply) begin
			head_q <= wmem[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status     <= ST_OK;
			new_id     <= '0;
			woke_valid <= 1'b0;
			woke_task  <= '0;
			last       <= 1'b0;
		end else if (ctl.res_load) begin
			status     <= ctl.res_status;
			new_id     <= ctl.res_new_id ? 8'(scan_idx) : 8'd0;
			woke_valid <= ctl.res_woke;
			woke_task  <= !ctl.res_woke ? 8'd0 : (cmd_q == CMD_POST) ? head_q : rd_q;
			last       <= ctl.res_last;
		end else if (out_take) begin
			last <= last;
		end
	end

	// status toward the controller
	always_comb begin
		sts.cmd         = cmd_q;
		sts.id_bad      = (id_q >= 8'(SEM_COUNT)) && (SEM_COUNT < 256);
		sts.slot_ok     = ok_q;
		sts.count_pos   = (cnt_q != '0);
		sts.queue_full  = (n_q >= NW'(QUEUE_DEPTH));
		sts.queue_empty = (n_q == '0);
		sts.scan_free   = !valid_q[scan_idx] && (scan_q < (SW+1)'(SEM_COUNT));
		sts.scan_done   = (scan_q >= (SW+1)'(SEM_COUNT - 1));
		sts.idx_last    = (idx_q >= n_q);
	end
endmodule
`default_nettype wire
